FILE: sv/htacc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Halo tidal acceleration package
// Shared item record, codes, fixed constants and unit depths.
// ----------------------------------------------------------------------------
package htacc_pkg;

	// Unit depths in pipeline stages; the log unit counts squaring steps
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int MUL_LAT    = 2;
	localparam int LN_STEPS   = 58;

	// Component select codes
	typedef enum logic [1:0] {
		OP_X    = 2'd0,
		OP_Y    = 2'd1,
		OP_Z    = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [1:0] REG_SCALE_RADIUS = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE    = 2'd1;

	localparam logic [30:0] SCALE_RADIUS_RESET = 31'd1342177;
	localparam logic [63:0] ONE_Q62            = 64'h4000_0000_0000_0000;
	localparam logic [63:0] HALF_Q62           = 64'h2000_0000_0000_0000;
	localparam logic [63:0] TWO_Q62            = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE_Q32            = 64'h0000_0001_0000_0000;
	localparam logic [63:0] INV_NUM_HI         = 64'h0000_0000_4000_0000;
	localparam logic [63:0] SERIES_LIMIT       = 64'h0000_0000_0100_0000;
	localparam logic [63:0] LN2_Q64            = 64'hB172_17F7_D1CF_79AB;
	localparam logic [63:0] POS_MAX            = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX            = 64'h8000_0000_0000_0000;

	// Reciprocals: floor(x/3) = (x * RECIP_3) >> 65, floor(x/15) = (x * RECIP_15) >> 67
	localparam logic [63:0] RECIP_3            = 64'hAAAA_AAAA_AAAA_AAAB;
	localparam logic [63:0] RECIP_15           = 64'h8888_8888_8888_8889;

	// One request in flight, with every intermediate value it collects
	typedef struct packed {
		logic         zero;
		logic         cneg;
		logic         series;
		logic         kneg;
		logic         sat;
		logic [31:0]  c;
		logic [31:0]  mx;
		logic [31:0]  my;
		logic [31:0]  mz;
		logic [31:0]  r;
		logic [4:0]   pexp;
		logic [57:0]  frac;
		logic [63:0]  sx;
		logic [63:0]  sy;
		logic [63:0]  sz;
		logic [63:0]  r2;
		logic [63:0]  s62;
		logic [63:0]  u;
		logic [63:0]  uu;
		logic [63:0]  u2;
		logic [63:0]  u3;
		logic [63:0]  u4;
		logic [63:0]  dd;
		logic [63:0]  d3;
		logic [63:0]  d12;
		logic [63:0]  d30;
		logic [63:0]  d60;
		logic [63:0]  pp;
		logic [63:0]  v;
		logic [63:0]  kser;
		logic [63:0]  inv;
		logic [63:0]  a1;
		logic [63:0]  a2;
		logic [63:0]  x;
		logic [63:0]  q58;
		logic [63:0]  l58;
		logic [63:0]  kmag;
		logic [63:0]  den;
		logic [63:0]  t;
		logic [127:0] prod;
	} item_t;

endpackage
`default_nettype wire

FILE: sv/htacc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined 64x64 multiplier
// Four 32x32 partial products in the first stage, full 128-bit sum in the second.
// ----------------------------------------------------------------------------
module htacc_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  htacc_pkg::item_t it_i,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	output logic             vld_o,
	output htacc_pkg::item_t it_o,
	output logic [127:0]     p
);
	logic             vld_s1, vld_s2;
	htacc_pkg::item_t it_s1, it_s2;
	logic [63:0]      p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0]     p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s1  <= it_i;
		p00_s1 <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
		p01_s1 <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
		p10_s1 <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
		p11_s1 <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
		it_s2  <= it_s1;
		p_s2   <= {p11_s1, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0};
	end

	assign vld_o = vld_s2;
	assign it_o  = it_s2;
	assign p     = p_s2;
endmodule
`default_nettype wire

FILE: sv/htacc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 128-by-64 division, one quotient bit per stage, 64 stages.
// ----------------------------------------------------------------------------
module htacc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  htacc_pkg::item_t it_i,
	input  logic [63:0]      num_hi,
	input  logic [63:0]      num_lo,
	input  logic [63:0]      dvs,
	output logic             vld_o,
	output htacc_pkg::item_t it_o,
	output logic [63:0]      quo
);
	localparam int STEPS = htacc_pkg::DIV_STEPS;

	logic             vld_s [0:STEPS];
	htacc_pkg::item_t it_s  [0:STEPS];
	logic [63:0]      hi_s  [0:STEPS];
	logic [63:0]      lo_s  [0:STEPS];
	logic [63:0]      d_s   [0:STEPS];
	logic [63:0]      q_s   [0:STEPS];

	assign vld_s[0] = vld_i;
	assign it_s[0]  = it_i;
	assign hi_s[0]  = num_hi;
	assign lo_s[0]  = num_lo;
	assign d_s[0]   = dvs;
	assign q_s[0]   = '0;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic        carry;
		logic [63:0] hi_sh, hi_nx, q_nx;

		// shift in one dividend bit, subtract when it fits
		always_comb begin
			carry = hi_s[k][63];
			hi_sh = {hi_s[k][62:0], lo_s[k][63]};
			if (carry || hi_sh >= d_s[k]) begin
				hi_nx = hi_sh - d_s[k];
				q_nx  = {q_s[k][62:0], 1'b1};
			end else begin
				hi_nx = hi_sh;
				q_nx  = {q_s[k][62:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			it_s[k+1] <= it_s[k];
			hi_s[k+1] <= hi_nx;
			lo_s[k+1] <= {lo_s[k][62:0], 1'b0};
			d_s[k+1]  <= d_s[k];
			q_s[k+1]  <= q_nx;
		end
	end

	assign vld_o = vld_s[STEPS];
	assign it_o  = it_s[STEPS];
	assign quo   = q_s[STEPS];
endmodule
`default_nettype wire

FILE: sv/htacc_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module htacc_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  htacc_pkg::item_t it_i,
	input  logic [63:0]      rad,
	output logic             vld_o,
	output htacc_pkg::item_t it_o,
	output logic [31:0]      root
);
	localparam int STEPS = htacc_pkg::SQRT_STEPS;

	logic             vld_s [0:STEPS];
	htacc_pkg::item_t it_s  [0:STEPS];
	logic [63:0]      rem_s [0:STEPS];
	logic [63:0]      res_s [0:STEPS];

	assign vld_s[0] = vld_i;
	assign it_s[0]  = it_i;
	assign rem_s[0] = rad;
	assign res_s[0] = '0;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial, rem_nx, res_nx;

		always_comb begin
			trial = res_s[k] + BIT;
			if (rem_s[k] >= trial) begin
				rem_nx = rem_s[k] - trial;
				res_nx = (res_s[k] >> 1) + BIT;
			end else begin
				rem_nx = rem_s[k];
				res_nx = res_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			it_s[k+1]  <= it_s[k];
			rem_s[k+1] <= rem_nx;
			res_s[k+1] <= res_nx;
		end
	end

	assign vld_o = vld_s[STEPS];
	assign it_o  = it_s[STEPS];
	assign root  = res_s[STEPS][31:0];
endmodule
`default_nettype wire

FILE: sv/htacc_ln.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Log2 fraction pipeline
// Squares the normalized mantissa once per step and collects 58 fraction bits.
// ----------------------------------------------------------------------------
module htacc_ln (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  htacc_pkg::item_t it_i,
	output logic             vld_o,
	output htacc_pkg::item_t it_o
);
	localparam int STEPS = htacc_pkg::LN_STEPS;

	logic             vld_c [0:STEPS];
	htacc_pkg::item_t it_c  [0:STEPS];

	assign vld_c[0] = vld_i;
	assign it_c[0]  = it_i;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic             vld_m;
		htacc_pkg::item_t it_m, nxt;
		logic [127:0]     p_m;
		logic [63:0]      sq;

		htacc_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_c[k]),
			.it_i   (it_c[k]),
			.a      (it_c[k].x),
			.b      (it_c[k].x),
			.vld_o  (vld_m),
			.it_o   (it_m),
			.p      (p_m)
		);

		// square reaching two: halve it and set this fraction bit
		always_comb begin
			sq  = p_m[125:62];
			nxt = it_m;
			if (sq[63]) begin
				nxt.x                = {1'b0, sq[63:1]};
				nxt.frac[STEPS-1-k] = 1'b1;
			end else begin
				nxt.x = sq;
			end
		end

		assign vld_c[k+1] = vld_m;
		assign it_c[k+1]  = nxt;
	end

	assign vld_o = vld_c[STEPS];
	assign it_o  = it_c[STEPS];
endmodule
`default_nettype wire

FILE: sv/halo_tidal_acceleration_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NFW halo tidal acceleration core
// One component of the tidal acceleration per request, fully pipelined.
// ----------------------------------------------------------------------------
// A request (operation, pos_x/y/z) is taken on every clock edge with start
// high; busy never rises, so one request per cycle is sustained. Each result
// appears on tidal_component/saturated for exactly one cycle with done high,
// once its request has run through 9 glue stages, a 32-stage square
// root, five 64-stage dividers, twelve 2-stage multipliers and a 58-step
// squaring chain for the logarithm, all in one line. Results leave in request
// order and cannot be held off. Write scale_radius and amplitude through the
// cfg port only while nothing is in flight.
module halo_tidal_acceleration_core #(
	parameter int COORD_FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               done,
	output logic signed [63:0] tidal_component,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_wdata
);
	localparam int TINY_LSB    = (1 << COORD_FRAC_BITS) / 1000000;
	localparam int SCALE_SHIFT = 2 * COORD_FRAC_BITS - 42;
	localparam int SHL         = (SCALE_SHIFT > 0) ? SCALE_SHIFT : 0;
	localparam int SHR         = (SCALE_SHIFT < 0) ? -SCALE_SHIFT : 0;
	localparam int LATENCY     = 9 + htacc_pkg::SQRT_STEPS + 5 * htacc_pkg::DIV_STEPS
		+ 12 * htacc_pkg::MUL_LAT + htacc_pkg::LN_STEPS * htacc_pkg::MUL_LAT;

	// ---------------- configuration ----------------
	logic [30:0] scale_radius_q;
	logic [47:0] amplitude_q;
	logic [63:0] rs_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_radius_q <= htacc_pkg::SCALE_RADIUS_RESET;
			amplitude_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				htacc_pkg::REG_SCALE_RADIUS: scale_radius_q <= cfg_wdata[30:0];
				htacc_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// rs^2 follows the register; it has settled long before any request uses it
	always_ff @(posedge clk) begin
		rs_sq_q <= {33'd0, scale_radius_q} * {33'd0, scale_radius_q};
	end

	assign busy = 1'b0;

	// ---------------- stage 1: magnitudes and zero cases ----------------
	logic             accept;
	logic [31:0]      mag_x, mag_y, mag_z;
	htacc_pkg::item_t it_in;
	logic             vld_s1, vld_s2, vld_s3;
	htacc_pkg::item_t it_s1, it_s2, it_s3;
	htacc_pkg::item_t it_nx2, it_nx3;

	assign accept = start && !busy;
	assign mag_x  = pos_x[31] ? ($unsigned(~pos_x) + 32'd1) : $unsigned(pos_x);
	assign mag_y  = pos_y[31] ? ($unsigned(~pos_y) + 32'd1) : $unsigned(pos_y);
	assign mag_z  = pos_z[31] ? ($unsigned(~pos_z) + 32'd1) : $unsigned(pos_z);

	always_comb begin
		it_in    = '0;
		it_in.mx = mag_x;
		it_in.my = mag_y;
		it_in.mz = mag_z;
		case (htacc_pkg::op_t'(operation))
			htacc_pkg::OP_X: begin
				it_in.c    = mag_x;
				it_in.cneg = pos_x[31];
			end
			htacc_pkg::OP_Y: begin
				it_in.c    = mag_y;
				it_in.cneg = pos_y[31];
			end
			htacc_pkg::OP_Z: begin
				it_in.c    = mag_z;
				it_in.cneg = pos_z[31];
			end
			default: begin
				it_in.c    = mag_x;
				it_in.cneg = 1'b0;
			end
		endcase
		// select three, zero scale radius or a tiny coordinate force a zero result
		it_in.zero = (htacc_pkg::op_t'(operation) == htacc_pkg::OP_NONE)
			|| (scale_radius_q == '0)
			|| (mag_x <= 32'(TINY_LSB)) || (mag_y <= 32'(TINY_LSB))
			|| (mag_z <= 32'(TINY_LSB));
	end

	// ---------------- stages 2 and 3: radius squared ----------------
	always_comb begin
		it_nx2    = it_s1;
		it_nx2.sx = {32'd0, it_s1.mx} * {32'd0, it_s1.mx};
		it_nx2.sy = {32'd0, it_s1.my} * {32'd0, it_s1.my};
		it_nx2.sz = {32'd0, it_s1.mz} * {32'd0, it_s1.mz};
		it_nx3    = it_s2;
		it_nx3.r2 = it_s2.sx + it_s2.sy + it_s2.sz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= it_in;
		it_s2 <= it_nx2;
		it_s3 <= it_nx3;
	end

	// ---------------- radius ----------------
	logic             vld_sq;
	htacc_pkg::item_t it_sq, it_a;
	logic [31:0]      root_sq;

	htacc_sqrt u_sqrt (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_s3), .it_i (it_s3), .rad (it_s3.r2),
		.vld_o (vld_sq), .it_o (it_sq), .root (root_sq)
	);

	always_comb begin
		it_a   = it_sq;
		it_a.r = root_sq;
	end

	// ---------------- direction cosine s = c / r in Q1.62 ----------------
	logic             vld_ds;
	htacc_pkg::item_t it_ds, it_b;
	logic [63:0]      q_ds;

	htacc_div u_div_s (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_sq), .it_i (it_a),
		.num_hi ({34'd0, it_a.c[31:2]}), .num_lo ({it_a.c[1:0], 62'd0}),
		.dvs ({32'd0, it_a.r}),
		.vld_o (vld_ds), .it_o (it_ds), .quo (q_ds)
	);

	always_comb begin
		it_b     = it_ds;
		it_b.s62 = q_ds;
	end

	// ---------------- u = r / rs in Q32.32 ----------------
	logic             vld_du;
	htacc_pkg::item_t it_du, it_c;
	logic [63:0]      q_du;

	htacc_div u_div_u (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_ds), .it_i (it_b),
		.num_hi ('0), .num_lo ({it_b.r, 32'd0}), .dvs ({33'd0, scale_radius_q}),
		.vld_o (vld_du), .it_o (it_du), .quo (q_du)
	);

	always_comb begin
		it_c        = it_du;
		it_c.u      = q_du;
		it_c.uu     = {q_du[33:0], 30'd0};
		it_c.series = q_du < htacc_pkg::SERIES_LIMIT;
	end

	// ---------------- series powers U^2, U^3, U^4 and (1+U)^2 ----------------
	logic             vld_m2, vld_m3, vld_m4, vld_md;
	htacc_pkg::item_t it_m2, it_m3, it_m4, it_md;
	htacc_pkg::item_t it_d, it_e, it_f, it_g;
	logic [127:0]     p_m2, p_m3, p_m4, p_md;

	htacc_mul u_mul_u2 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_du), .it_i (it_c), .a (it_c.uu), .b (it_c.uu),
		.vld_o (vld_m2), .it_o (it_m2), .p (p_m2)
	);

	always_comb begin
		it_d    = it_m2;
		it_d.u2 = p_m2[125:62];
	end

	htacc_mul u_mul_u3 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_m2), .it_i (it_d), .a (it_d.u2), .b (it_d.uu),
		.vld_o (vld_m3), .it_o (it_m3), .p (p_m3)
	);

	always_comb begin
		it_e    = it_m3;
		it_e.u3 = p_m3[125:62];
	end

	htacc_mul u_mul_u4 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_m3), .it_i (it_e), .a (it_e.u3), .b (it_e.uu),
		.vld_o (vld_m4), .it_o (it_m4), .p (p_m4)
	);

	always_comb begin
		it_f    = it_m4;
		it_f.u4 = p_m4[125:62];
	end

	// 1 + U only touches the top two bits
	logic [63:0] one_u;
	assign one_u = {it_f.uu[63:62] + 2'b01, it_f.uu[61:0]};

	htacc_mul u_mul_dd (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_m4), .it_i (it_f), .a (one_u), .b (one_u),
		.vld_o (vld_md), .it_o (it_md), .p (p_md)
	);

	always_comb begin
		it_g    = it_md;
		it_g.dd = p_md[125:62];
	end

	// ---------------- series terms divided by their integers ----------------
	// Multiply by a reciprocal and keep the high bits; 12, 30 and 60 first
	// drop their factor of four or two by a shift, then divide by 3 or 15.
	logic             vld_d3, vld_d12, vld_d30, vld_d60;
	htacc_pkg::item_t it_d3, it_d12, it_d30, it_d60;
	htacc_pkg::item_t it_h, it_i2, it_j, it_k;
	logic [127:0]     p_d3, p_d12, p_d30, p_d60;

	htacc_mul u_mul_d3 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_md), .it_i (it_g), .a (it_g.uu), .b (htacc_pkg::RECIP_3),
		.vld_o (vld_d3), .it_o (it_d3), .p (p_d3)
	);

	always_comb begin
		it_h    = it_d3;
		it_h.d3 = {1'b0, p_d3[127:65]};
	end

	htacc_mul u_mul_d12 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_d3), .it_i (it_h), .a ({2'd0, it_h.u2[63:2]}),
		.b (htacc_pkg::RECIP_3),
		.vld_o (vld_d12), .it_o (it_d12), .p (p_d12)
	);

	always_comb begin
		it_i2     = it_d12;
		it_i2.d12 = {1'b0, p_d12[127:65]};
	end

	htacc_mul u_mul_d30 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_d12), .it_i (it_i2), .a ({1'b0, it_i2.u3[63:1]}),
		.b (htacc_pkg::RECIP_15),
		.vld_o (vld_d30), .it_o (it_d30), .p (p_d30)
	);

	always_comb begin
		it_j     = it_d30;
		it_j.d30 = {3'd0, p_d30[127:67]};
	end

	htacc_mul u_mul_d60 (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_d30), .it_i (it_j), .a ({2'd0, it_j.u4[63:2]}),
		.b (htacc_pkg::RECIP_15),
		.vld_o (vld_d60), .it_o (it_d60), .p (p_d60)
	);

	always_comb begin
		it_k     = it_d60;
		it_k.d60 = {3'd0, p_d60[127:67]};
	end

	// ---------------- stage 4: series numerator and v = 1 + u ----------------
	logic             vld_s4;
	htacc_pkg::item_t it_s4, it_nx4;

	always_comb begin
		it_nx4    = it_k;
		it_nx4.pp = htacc_pkg::HALF_Q62 - it_k.d3 + it_k.d12 - it_k.d30 + it_k.d60;
		it_nx4.v  = it_k.u + htacc_pkg::ONE_Q32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_d60;
		end
	end

	always_ff @(posedge clk) begin
		it_s4 <= it_nx4;
	end

	// ---------------- series k = P / (1+U)^2 ----------------
	logic             vld_dk;
	htacc_pkg::item_t it_dk, it_l;
	logic [63:0]      q_dk;

	htacc_div u_div_k (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_s4), .it_i (it_s4),
		.num_hi ({2'd0, it_s4.pp[63:2]}), .num_lo ({it_s4.pp[1:0], 62'd0}),
		.dvs (it_s4.dd),
		.vld_o (vld_dk), .it_o (it_dk), .quo (q_dk)
	);

	always_comb begin
		it_l      = it_dk;
		it_l.kser = {4'd0, q_dk[63:4]};
	end

	// ---------------- i = 1 / v in Q62 ----------------
	logic             vld_di;
	htacc_pkg::item_t it_di, it_m;
	logic [63:0]      q_di;

	htacc_div u_div_i (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_dk), .it_i (it_l),
		.num_hi (htacc_pkg::INV_NUM_HI), .num_lo ('0), .dvs (it_l.v),
		.vld_o (vld_di), .it_o (it_di), .quo (q_di)
	);

	always_comb begin
		it_m     = it_di;
		it_m.inv = q_di;
	end

	// ---------------- stages 5 and 6: factors and log normalization ----------------
	logic             vld_s5, vld_s6;
	htacc_pkg::item_t it_s5, it_s6, it_nx5, it_nx6;
	logic [4:0]       top_pos;

	// highest set bit of v above bit 32, else bit 32
	always_comb begin
		top_pos = 5'd0;
		for (int b = 33; b < 64; b++) begin
			if (it_m.v[b]) top_pos = 5'(b - 32);
		end
	end

	always_comb begin
		it_nx5      = it_m;
		it_nx5.a1   = htacc_pkg::ONE_Q62 - it_m.inv;
		it_nx5.a2   = htacc_pkg::TWO_Q62 - it_m.inv;
		it_nx5.pexp = top_pos;
		it_nx6      = it_s5;
		it_nx6.frac = '0;
		it_nx6.x    = (it_s5.pexp == 5'd31) ? {1'b0, it_s5.v[63:1]}
			: (it_s5.v << (5'd30 - it_s5.pexp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= vld_di;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		it_s5 <= it_nx5;
		it_s6 <= it_nx6;
	end

	// ---------------- (1-i)(2-i) in Q58 ----------------
	logic             vld_mq;
	htacc_pkg::item_t it_mq, it_n;
	logic [127:0]     p_mq;

	htacc_mul u_mul_q (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_s6), .it_i (it_s6), .a (it_s6.a1), .b (it_s6.a2),
		.vld_o (vld_mq), .it_o (it_mq), .p (p_mq)
	);

	always_comb begin
		it_n     = it_mq;
		it_n.q58 = {4'd0, p_mq[125:66]};
	end

	// ---------------- log2 fraction, then scale by ln 2 ----------------
	logic             vld_ln, vld_ml;
	htacc_pkg::item_t it_ln, it_ml, it_o2;
	logic [127:0]     p_ml;

	htacc_ln u_ln (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_mq), .it_i (it_n),
		.vld_o (vld_ln), .it_o (it_ln)
	);

	htacc_mul u_mul_l (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_ln), .it_i (it_ln),
		.a ({1'b0, it_ln.pexp, it_ln.frac}), .b (htacc_pkg::LN2_Q64),
		.vld_o (vld_ml), .it_o (it_ml), .p (p_ml)
	);

	always_comb begin
		it_o2     = it_ml;
		it_o2.l58 = p_ml[127:64];
	end

	// ---------------- stage 7: pick branch, magnitude and sign of k ----------------
	logic             vld_s7;
	htacc_pkg::item_t it_s7, it_nx7;
	logic             l_gt;

	assign l_gt = it_o2.l58 > it_o2.q58;

	always_comb begin
		it_nx7      = it_o2;
		it_nx7.kneg = !it_o2.series && l_gt;
		it_nx7.kmag = it_o2.series ? it_o2.kser
			: (l_gt ? (it_o2.l58 - it_o2.q58) : (it_o2.q58 - it_o2.l58));
		it_nx7.den  = it_o2.series ? rs_sq_q : it_o2.r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_ml;
		end
	end

	always_ff @(posedge clk) begin
		it_s7 <= it_nx7;
	end

	// ---------------- t = s * k, then A * t ----------------
	logic             vld_mt, vld_ma;
	htacc_pkg::item_t it_mt, it_ma, it_p, it_q;
	logic [127:0]     p_mt, p_ma;

	htacc_mul u_mul_t (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_s7), .it_i (it_s7), .a (it_s7.s62), .b (it_s7.kmag),
		.vld_o (vld_mt), .it_o (it_mt), .p (p_mt)
	);

	always_comb begin
		it_p   = it_mt;
		it_p.t = p_mt[125:62];
	end

	htacc_mul u_mul_a (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_mt), .it_i (it_p), .a ({16'd0, amplitude_q}), .b (it_p.t),
		.vld_o (vld_ma), .it_o (it_ma), .p (p_ma)
	);

	always_comb begin
		it_q      = it_ma;
		it_q.prod = p_ma;
	end

	// ---------------- stage 8: fixed-point rescale and overflow check ----------------
	logic             vld_s8;
	htacc_pkg::item_t it_s8, it_nx8;
	logic [127:0]     scaled;
	logic             shift_ovf;

	// bits shifted out the top, or a quotient that would not fit, saturate
	assign scaled    = (it_q.prod << SHL) >> SHR;
	assign shift_ovf = (it_q.prod >> (128 - SHL)) != '0;

	always_comb begin
		it_nx8      = it_q;
		it_nx8.prod = scaled;
		it_nx8.sat  = shift_ovf || (scaled[127:64] >= it_q.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_ma;
		end
	end

	always_ff @(posedge clk) begin
		it_s8 <= it_nx8;
	end

	// ---------------- final division by rs^2 or r^2 ----------------
	logic             vld_df;
	htacc_pkg::item_t it_df;
	logic [63:0]      q_df;

	htacc_div u_div_f (
		.clk (clk), .arst_n (arst_n),
		.vld_i (vld_s8), .it_i (it_s8),
		.num_hi (it_s8.prod[127:64]), .num_lo (it_s8.prod[63:0]), .dvs (it_s8.den),
		.vld_o (vld_df), .it_o (it_df), .quo (q_df)
	);

	// ---------------- stage 9: sign, clamp and drive the result ----------------
	logic        done_s9, sat_s9, res_sat, res_neg;
	logic [63:0] tc_s9, res_val;

	always_comb begin
		res_neg = it_df.cneg == it_df.kneg;
		res_sat = 1'b0;
		res_val = '0;
		if (it_df.zero) begin
			res_val = '0;
		end else if (res_neg) begin
			if (it_df.sat || q_df > htacc_pkg::NEG_MAX) begin
				res_val = htacc_pkg::NEG_MAX;
				res_sat = 1'b1;
			end else begin
				res_val = '0 - q_df;
			end
		end else begin
			if (it_df.sat || q_df > htacc_pkg::POS_MAX) begin
				res_val = htacc_pkg::POS_MAX;
				res_sat = 1'b1;
			end else begin
				res_val = q_df;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s9 <= 1'b0;
		end else begin
			done_s9 <= vld_df;
		end
	end

	always_ff @(posedge clk) begin
		tc_s9  <= res_val;
		sat_s9 <= res_sat;
	end

	assign done            = done_s9;
	assign tidal_component = $signed(tc_s9);
	assign saturated       = sat_s9;

`ifndef SYNTH
	// every request comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request did not complete after the pipeline depth");

	// a saturated result sits at one end of the range
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(tc_s9 == htacc_pkg::POS_MAX || tc_s9 == htacc_pkg::NEG_MAX))
		else $error("saturated result not clamped to range end");

	// a zero-forced request never reports saturation
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_df && it_df.zero) |=> (done && !saturated && tc_s9 == '0))
		else $error("forced-zero request produced a nonzero result");
`endif
endmodule
`default_nettype wire
